[rtl/core/nrrd_pkg.sv]
// Shared types and codes of the nibble run-length raster decoder.
package nrrd_pkg;

	// Result kinds
	localparam logic [2:0] KIND_RUN      = 3'd0;
	localparam logic [2:0] KIND_COMPLETE = 3'd1;
	localparam logic [2:0] KIND_SHORT    = 3'd2;
	localparam logic [2:0] KIND_TRUNC    = 3'd3;
	localparam logic [2:0] KIND_ZERO     = 3'd4;

	// Decode phases
	localparam logic [1:0] PH_RUN   = 2'd0;
	localparam logic [1:0] PH_LEN2  = 2'd1;
	localparam logic [1:0] PH_FULL  = 2'd2;
	localparam logic [1:0] PH_ERROR = 2'd3;

	// Configuration register indexes
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Fixed field widths
	localparam int RUN_LEN_W = 12;
	localparam int NIB_W     = 4;
	localparam int BYTE_W    = 8;
	localparam int KIND_W    = 3;
	localparam int FLAG_W    = 3;

	// Nibble codes that take a two-byte length
	localparam logic [NIB_W-1:0] COLOR_BLACK = 4'h0;
	localparam logic [NIB_W-1:0] COLOR_WHITE = 4'hf;

	// Queue depth between front and back
	localparam int QUEUE_DEPTH = 2;

	// One queued request
	typedef struct packed {
		logic [BYTE_W-1:0] code_byte;
		logic              last;
		logic              is_long;
	} q_item_t;

	// Back-end sequencer states
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIVS = 5'b00010,
		ST_DIVE = 5'b00100,
		ST_RUN  = 5'b01000,
		ST_TAIL = 5'b10000
	} back_state_t;

endpackage

[rtl/core/nrrd_front.sv]
// Input front: accepts bytes, tags two-byte runs, and queues them for the back end.
module nrrd_front
	import nrrd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] code_byte,
	input  logic              stream_last,
	output q_item_t           item,
	output logic              item_valid,
	input  logic              item_pop
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	q_item_t          mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;
	q_item_t          new_item;

	// Classify the incoming byte
	always_comb begin
		new_item.code_byte = code_byte;
		new_item.last      = stream_last;
		new_item.is_long   = (code_byte[BYTE_W-1:NIB_W] == COLOR_BLACK) ||
		                     (code_byte[BYTE_W-1:NIB_W] == COLOR_WHITE);
	end

	assign in_stall   = (count_q == CNT_W'(QUEUE_DEPTH));
	assign push       = in_valid && !in_stall;
	assign item_valid = (count_q != '0);
	assign pop        = item_pop && item_valid;
	assign item       = mem_q[rd_ptr_q];

	// Store the request
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/core/nrrd_div.sv]
// Restoring divider, one quotient bit per cycle.
module nrrd_div
	import nrrd_pkg::*;
#(
	parameter int DIVIDEND_W = 28,
	parameter int DIVISOR_W  = 14
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic [DIVIDEND_W-1:0] quotient,
	output logic [DIVISOR_W-1:0]  remainder,
	output logic                  done
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W:0]    rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIVISOR_W:0]    shifted;
	logic [DIVISOR_W+1:0]  trial;

	// One restoring step
	always_comb begin
		shifted = {rem_q[DIVISOR_W-1:0], quo_q[DIVIDEND_W-1]};
		trial   = {1'b0, shifted} - {2'b00, dvs_q};
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (trial[DIVISOR_W+1]) begin
				rem_q <= shifted;
				quo_q <= {quo_q[DIVIDEND_W-2:0], 1'b0};
			end else begin
				rem_q <= trial[DIVISOR_W:0];
				quo_q <= {quo_q[DIVIDEND_W-2:0], 1'b1};
			end
		end
	end

	// Count the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (go) begin
				cnt_q  <= CNT_W'(DIVIDEND_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q  <= cnt_q - 1'b1;
				busy_q <= (cnt_q != CNT_W'(1));
			end
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q[DIVISOR_W-1:0];
	assign done      = done_q;

endmodule

[rtl/core/nrrd_back.sv]
// Back end: decodes queued bytes, tracks the box and emits results.
module nrrd_back
	import nrrd_pkg::*;
#(
	parameter int COORD_BITS      = 14,
	parameter int BYTE_COUNT_BITS = 29
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  q_item_t                      item,
	input  logic                         item_valid,
	output logic                         item_pop,
	input  logic [COORD_BITS-1:0]        width,
	input  logic [2*COORD_BITS-1:0]      expected,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [KIND_W-1:0]            result_kind,
	output logic [NIB_W-1:0]             run_color,
	output logic [2*COORD_BITS-1:0]      run_start,
	output logic [RUN_LEN_W-1:0]         run_length,
	output logic [COORD_BITS-1:0]        box_min_x,
	output logic [COORD_BITS-1:0]        box_min_y,
	output logic [COORD_BITS-1:0]        box_max_x,
	output logic [COORD_BITS-1:0]        box_max_y,
	output logic                         box_present,
	output logic [BYTE_COUNT_BITS-1:0]   bytes_used,
	output logic [FLAG_W-1:0]            note_flags,
	output logic                         frame_end
);

	localparam int PIX_W = 2 * COORD_BITS;
	localparam int CW    = COORD_BITS;

	back_state_t state_q;

	// Frame state
	logic [1:0]                 phase_q;
	logic [BYTE_W-1:0]          held_q;
	logic [PIX_W-1:0]           pd_q;
	logic [CW-1:0]              min_x_q, min_y_q, max_x_q, max_y_q;
	logic                       box_valid_q;
	logic [BYTE_COUNT_BITS-1:0] tally_q;
	logic [FLAG_W-1:0]          flags_q;

	// Pending work of the current request
	logic [NIB_W-1:0]     color_q;
	logic [PIX_W-1:0]     start_q;
	logic [RUN_LEN_W-1:0] len_q;
	logic [KIND_W-1:0]    tail_kind_q;
	logic                 tail_valid_q;
	logic                 clear_q;
	logic [PIX_W-1:0]     qs_q;
	logic [CW-1:0]        rs_q;
	logic                 div_go_q;

	// Output register
	logic                       out_valid_q;
	logic [KIND_W-1:0]          kind_o_q;
	logic [NIB_W-1:0]           color_o_q;
	logic [PIX_W-1:0]           start_o_q;
	logic [RUN_LEN_W-1:0]       len_o_q;
	logic [CW-1:0]              min_x_o_q, min_y_o_q, max_x_o_q, max_y_o_q;
	logic                       box_o_q;
	logic [BYTE_COUNT_BITS-1:0] tally_o_q;
	logic [FLAG_W-1:0]          flags_o_q;
	logic                       fend_o_q;

	// Decode terms
	logic [RUN_LEN_W-1:0] raw_len;
	logic [NIB_W-1:0]     dec_color;
	logic [PIX_W-1:0]     remain;
	logic                 clamp;
	logic [RUN_LEN_W-1:0] len_c;
	logic [PIX_W-1:0]     pd_new;
	logic [PIX_W-1:0]     end_pix;
	logic                 out_free;
	logic                 load_run;
	logic                 load_tail;
	logic                 clear_now;
	logic [PIX_W-1:0]     div_quo;
	logic [CW-1:0]        div_rem;
	logic                 div_done;
	logic [CW-1:0]        x0, x1, y0, y1;

	// Decode the current byte
	always_comb begin
		if (phase_q == PH_LEN2) begin
			raw_len   = {held_q[NIB_W-1:0], item.code_byte};
			dec_color = held_q[BYTE_W-1:NIB_W];
		end else begin
			raw_len   = {{(RUN_LEN_W-NIB_W){1'b0}}, item.code_byte[NIB_W-1:0]};
			dec_color = item.code_byte[BYTE_W-1:NIB_W];
		end
		remain  = (expected > pd_q) ? expected - pd_q : '0;
		clamp   = {{(PIX_W-RUN_LEN_W){1'b0}}, raw_len} > remain;
		len_c   = clamp ? remain[RUN_LEN_W-1:0] : raw_len;
		pd_new  = pd_q + {{(PIX_W-RUN_LEN_W){1'b0}}, len_c};
		end_pix = start_q + {{(PIX_W-RUN_LEN_W){1'b0}}, len_q} - 1'b1;
	end

	assign item_pop  = (state_q == ST_IDLE) && item_valid;
	assign out_free  = !out_valid_q || !out_stall;
	assign load_run  = (state_q == ST_RUN) && out_free;
	assign load_tail = (state_q == ST_TAIL) && out_free;
	assign clear_now = (item_pop && (phase_q == PH_ERROR) && item.last) ||
	                   (load_tail && clear_q);

	nrrd_div #(
		.DIVIDEND_W (PIX_W),
		.DIVISOR_W  (CW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (div_go_q),
		.dividend  ((state_q == ST_DIVE) ? end_pix : start_q),
		.divisor   (width),
		.quotient  (div_quo),
		.remainder (div_rem),
		.done      (div_done)
	);

	// Box extent of the run just divided
	always_comb begin
		y0 = qs_q[CW-1:0];
		y1 = div_quo[CW-1:0];
		if (qs_q == div_quo) begin
			x0 = rs_q;
			x1 = div_rem;
		end else begin
			x0 = '0;
			x1 = width - 1'b1;
		end
	end

	// Payload of the run plan and division results
	always_ff @(posedge clk) begin
		if (item_pop) begin
			color_q <= dec_color;
			start_q <= pd_q;
			len_q   <= len_c;
		end
		if (state_q == ST_DIVS && div_done) begin
			qs_q <= div_quo;
			rs_q <= div_rem;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load_run || load_tail) begin
			kind_o_q  <= load_run ? KIND_RUN : tail_kind_q;
			color_o_q <= load_run ? color_q : '0;
			start_o_q <= load_run ? start_q : '0;
			len_o_q   <= load_run ? len_q : '0;
			fend_o_q  <= load_tail;
			min_x_o_q <= min_x_q;
			min_y_o_q <= min_y_q;
			max_x_o_q <= max_x_q;
			max_y_o_q <= max_y_q;
			box_o_q   <= box_valid_q;
			tally_o_q <= tally_q;
			flags_o_q <= flags_q;
		end
	end

	// Sequencer and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= PH_RUN;
			held_q       <= '0;
			pd_q         <= '0;
			min_x_q      <= '0;
			min_y_q      <= '0;
			max_x_q      <= '0;
			max_y_q      <= '0;
			box_valid_q  <= 1'b0;
			tally_q      <= '0;
			flags_q      <= '0;
			tail_kind_q  <= KIND_COMPLETE;
			tail_valid_q <= 1'b0;
			clear_q      <= 1'b0;
			div_go_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			div_go_q    <= 1'b0;
			out_valid_q <= (load_run || load_tail) ? 1'b1 : (out_valid_q && out_stall);
			unique case (state_q)
				ST_IDLE: begin
					if (item_pop) begin
						tail_valid_q <= 1'b0;
						clear_q      <= 1'b0;
						if (phase_q == PH_ERROR) begin
							// drop the byte silently
							phase_q <= PH_ERROR;
						end else if (phase_q == PH_FULL ||
						             (phase_q == PH_RUN && pd_q >= expected)) begin
							// trailing byte after a full raster
							phase_q <= PH_FULL;
							flags_q <= flags_q | 3'b010;
							if (item.last) begin
								tail_kind_q <= KIND_COMPLETE;
								clear_q     <= 1'b1;
								state_q     <= ST_TAIL;
							end
						end else begin
							if (!(&tally_q)) begin
								tally_q <= tally_q + 1'b1;
							end
							if (phase_q == PH_RUN && item.is_long) begin
								if (item.last) begin
									tail_kind_q <= KIND_TRUNC;
									clear_q     <= 1'b1;
									state_q     <= ST_TAIL;
								end else begin
									held_q  <= item.code_byte;
									phase_q <= PH_LEN2;
								end
							end else if (raw_len == '0) begin
								flags_q     <= flags_q | {phase_q == PH_RUN, 2'b00};
								tail_kind_q <= KIND_ZERO;
								clear_q     <= item.last;
								phase_q     <= PH_ERROR;
								state_q     <= ST_TAIL;
							end else begin
								flags_q <= flags_q | {phase_q == PH_RUN, 1'b0, clamp};
								pd_q    <= pd_new;
								if (pd_new >= expected) begin
									phase_q      <= PH_FULL;
									tail_kind_q  <= KIND_COMPLETE;
								end else begin
									phase_q      <= PH_RUN;
									tail_kind_q  <= KIND_SHORT;
								end
								tail_valid_q <= item.last;
								clear_q      <= item.last;
								if (dec_color != '0 && len_c != '0) begin
									div_go_q <= 1'b1;
									state_q  <= ST_DIVS;
								end else begin
									state_q  <= ST_RUN;
								end
							end
						end
					end
				end
				ST_DIVS: begin
					if (div_done) begin
						div_go_q <= 1'b1;
						state_q  <= ST_DIVE;
					end
				end
				ST_DIVE: begin
					if (div_done) begin
						// merge the run into the box
						if (!box_valid_q) begin
							min_x_q     <= x0;
							max_x_q     <= x1;
							min_y_q     <= y0;
							max_y_q     <= y1;
							box_valid_q <= 1'b1;
						end else begin
							if (x0 < min_x_q) min_x_q <= x0;
							if (y0 < min_y_q) min_y_q <= y0;
							if (x1 > max_x_q) max_x_q <= x1;
							if (y1 > max_y_q) max_y_q <= y1;
						end
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (load_run) begin
						state_q <= tail_valid_q ? ST_TAIL : ST_IDLE;
					end
				end
				ST_TAIL: begin
					if (load_tail) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// return the frame state to zero at frame end
			if (clear_now) begin
				phase_q     <= PH_RUN;
				held_q      <= '0;
				pd_q        <= '0;
				min_x_q     <= '0;
				min_y_q     <= '0;
				max_x_q     <= '0;
				max_y_q     <= '0;
				box_valid_q <= 1'b0;
				tally_q     <= '0;
				flags_q     <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = kind_o_q;
	assign run_color   = color_o_q;
	assign run_start   = start_o_q;
	assign run_length  = len_o_q;
	assign box_min_x   = min_x_o_q;
	assign box_min_y   = min_y_o_q;
	assign box_max_x   = max_x_o_q;
	assign box_max_y   = max_y_o_q;
	assign box_present = box_o_q;
	assign bytes_used  = tally_o_q;
	assign note_flags  = flags_o_q;
	assign frame_end   = fend_o_q;

endmodule

[rtl/core/nibble_rle_raster_decoder.sv]
// Top level of the nibble run-length raster decoder.
//
//  channel | direction | handshake          | payload
//  input   | in        | in_valid/in_stall  | code_byte, stream_last
//  result  | out       | out_valid/out_stall| result_kind .. frame_end
//  config  | in        | cfg_we             | cfg_index, cfg_data
//
// A byte that yields no result is only taken in. One that yields only a final
// result sends it straight to the output register, and so does a run of color 0
// or one clamped to nothing. A run of nonzero color first passes through the
// bit-serial divider that finds the run's start and end rows and columns.
// A final result follows its run; each result waits while out_stall holds it.
// A two-entry queue keeps taking bytes, until it is full, while the back end works
// or while a result waits under out_stall. Reset clears all control and frame state.
module nibble_rle_raster_decoder
	import nrrd_pkg::*;
#(
	parameter int COORD_BITS      = 14,
	parameter int BYTE_COUNT_BITS = 29
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [COORD_BITS-1:0]        cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [BYTE_W-1:0]            code_byte,
	input  logic                         stream_last,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [KIND_W-1:0]            result_kind,
	output logic [NIB_W-1:0]             run_color,
	output logic [2*COORD_BITS-1:0]      run_start,
	output logic [RUN_LEN_W-1:0]         run_length,
	output logic [COORD_BITS-1:0]        box_min_x,
	output logic [COORD_BITS-1:0]        box_min_y,
	output logic [COORD_BITS-1:0]        box_max_x,
	output logic [COORD_BITS-1:0]        box_max_y,
	output logic                         box_present,
	output logic [BYTE_COUNT_BITS-1:0]   bytes_used,
	output logic [FLAG_W-1:0]            note_flags,
	output logic                         frame_end
);

	localparam int PIX_W = 2 * COORD_BITS;

	logic [COORD_BITS-1:0] width_q;
	logic [COORD_BITS-1:0] height_q;
	logic [PIX_W-1:0]      expected_q;
	q_item_t               item;
	logic                  item_valid;
	logic                  item_pop;

	// Hold the raster size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= COORD_BITS'(1);
			height_q   <= COORD_BITS'(1);
			expected_q <= PIX_W'(1);
		end else begin
			if (cfg_we && cfg_index == REG_WIDTH) width_q <= cfg_data;
			if (cfg_we && cfg_index == REG_HEIGHT) height_q <= cfg_data;
			expected_q <= {{COORD_BITS{1'b0}}, width_q} * {{COORD_BITS{1'b0}}, height_q};
		end
	end

	nrrd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.code_byte   (code_byte),
		.stream_last (stream_last),
		.item        (item),
		.item_valid  (item_valid),
		.item_pop    (item_pop)
	);

	nrrd_back #(
		.COORD_BITS      (COORD_BITS),
		.BYTE_COUNT_BITS (BYTE_COUNT_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.item_valid  (item_valid),
		.item_pop    (item_pop),
		.width       (width_q),
		.expected    (expected_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.run_color   (run_color),
		.run_start   (run_start),
		.run_length  (run_length),
		.box_min_x   (box_min_x),
		.box_min_y   (box_min_y),
		.box_max_x   (box_max_x),
		.box_max_y   (box_max_y),
		.box_present (box_present),
		.bytes_used  (bytes_used),
		.note_flags  (note_flags),
		.frame_end   (frame_end)
	);

	// A run never ends the frame
	a_run_not_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_RUN |-> !frame_end)
		else $error("run result marked as frame end");

	// An empty box reads as zero
	a_box_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !box_present |->
		box_min_x == '0 && box_min_y == '0 && box_max_x == '0 && box_max_y == '0)
		else $error("box fields set without a box");

	// A zero-length run result comes only from clamping
	a_len_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_RUN |-> run_length != '0 || note_flags[0])
		else $error("empty run without clamp flag");

endmodule
